// File: sv/fsir_pkg.sv
package fsir_pkg;

    localparam int TABLE_DEPTH = 65536;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);

    localparam int INDEX_W  = 16;
    localparam int MEDIUM_W = 4;
    localparam int BASE_W   = 24;
    localparam int COUNT_W  = 17;
    localparam int EPOCH_W  = 7;
    localparam int RESULT_W = 25;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_BASE_OFFSET   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_MEDIUM = 2'd1;

    localparam logic CMD_MAP      = 1'b0;
    localparam logic CMD_NEW_PASS = 1'b1;

    typedef struct packed {
        logic               valid;
        logic [EPOCH_W-1:0] tag;
        logic [COUNT_W-1:0] num;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

// File: sv/fsir_ram.sv
module fsir_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: sv/first_seen_index_renumbering.sv
// Channel   Dir  Handshake            Payload
// in        in   in_valid / in_stall  command, old_index, medium_req
// out       out  out_valid / out_stall new_index, remapped, first_seen, unique_count
// cfg       in   cfg_valid / cfg_ready cfg_index, cfg_data
//
// Each request first reads its table entry from the synchronous RAM, then loads
// the output register and, on a miss, writes the new entry back to the table.
// Only one request is in flight, so reads never overlap a pending write.
// After reset, and after every 128th new-pass command (epoch wrap), a clearing
// pass writes all 65536 entries, one per cycle; in_stall stays high meanwhile.
// in_stall is also high while the output register holds an untaken result.
module first_seen_index_renumbering
    import fsir_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 command,
    input  logic [INDEX_W-1:0]   old_index,
    input  logic [MEDIUM_W-1:0]  medium_req,

    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [RESULT_W-1:0]  new_index,
    output logic                 remapped,
    output logic                 first_seen,
    output logic [COUNT_W-1:0]   unique_count,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BASE_W-1:0]    cfg_data
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK
    } state_t;

    state_t              state_reg;
    logic [ADDR_W-1:0]   clr_addr_reg;
    logic                cmd_reg;
    logic [INDEX_W-1:0]  idx_reg;
    logic [MEDIUM_W-1:0] med_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic [COUNT_W-1:0]  count_next;
    logic [EPOCH_W-1:0]  epoch_reg;
    logic [EPOCH_W-1:0]  epoch_next;
    logic [BASE_W-1:0]   base_reg;
    logic [MEDIUM_W-1:0] medium_reg;

    logic                out_valid_reg;
    logic [RESULT_W-1:0] new_index_reg;
    logic                remapped_reg;
    logic                first_seen_reg;
    logic [COUNT_W-1:0]  unique_count_reg;

    logic [RESULT_W-1:0] res_index;
    logic                res_remap;
    logic                res_fresh;
    logic [COUNT_W-1:0]  res_count;

    logic                accept_in;
    logic                in_range;
    logic                hit;
    logic                miss_write;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    entry_t              ram_wdata;
    entry_t              rd_entry;
    logic [ENTRY_W-1:0]  ram_rdata;

    assign in_stall  = !((state_reg == S_IDLE) && (!out_valid_reg || !out_stall));
    assign accept_in = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    assign out_valid    = out_valid_reg;
    assign new_index    = new_index_reg;
    assign remapped     = remapped_reg;
    assign first_seen   = first_seen_reg;
    assign unique_count = unique_count_reg;

    assign rd_entry   = entry_t'(ram_rdata);
    assign in_range   = (32'(idx_reg) < TABLE_DEPTH);
    assign hit        = rd_entry.valid && (rd_entry.tag == epoch_reg);
    assign epoch_next = epoch_reg + EPOCH_W'(1);

    always_comb
    begin
        res_index  = '0;
        res_remap  = 1'b0;
        res_fresh  = 1'b0;
        res_count  = count_reg;
        count_next = count_reg;
        miss_write = 1'b0;
        if (cmd_reg == CMD_NEW_PASS)
        begin
            count_next = '0;
        end
        else if ((med_reg != medium_reg) || !in_range)
        begin
            res_index = RESULT_W'(idx_reg);
        end
        else if (!hit)
        begin
            res_index  = RESULT_W'(base_reg) + RESULT_W'(count_reg);
            res_remap  = 1'b1;
            res_fresh  = 1'b1;
            count_next = count_reg + COUNT_W'(1);
            res_count  = count_next;
            miss_write = 1'b1;
        end
        else
        begin
            res_index = RESULT_W'(base_reg) + RESULT_W'(rd_entry.num);
            res_remap = 1'b1;
        end
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = clr_addr_reg;
        ram_wdata = '0;
        if (state_reg == S_CLEAR)
        begin
            ram_we = 1'b1;
        end
        else if ((state_reg == S_LOOK) && miss_write)
        begin
            ram_we          = 1'b1;
            ram_waddr       = ADDR_W'(idx_reg);
            ram_wdata.valid = 1'b1;
            ram_wdata.tag   = epoch_reg;
            ram_wdata.num   = count_reg;
        end
    end

    fsir_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ADDR_W'(old_index)),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            cmd_reg <= command;
            idx_reg <= old_index;
            med_reg <= medium_req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg   <= '0;
            medium_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_BASE_OFFSET:   base_reg   <= cfg_data;
                REG_TARGET_MEDIUM: medium_reg <= cfg_data[MEDIUM_W-1:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            clr_addr_reg     <= '0;
            count_reg        <= '0;
            epoch_reg        <= '0;
            out_valid_reg    <= 1'b0;
            new_index_reg    <= '0;
            remapped_reg     <= 1'b0;
            first_seen_reg   <= 1'b0;
            unique_count_reg <= '0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
                    if (clr_addr_reg == ADDR_W'(TABLE_DEPTH - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (accept_in)
                    begin
                        state_reg <= S_LOOK;
                    end
                end
                S_LOOK:
                begin
                    out_valid_reg    <= 1'b1;
                    new_index_reg    <= res_index;
                    remapped_reg     <= res_remap;
                    first_seen_reg   <= res_fresh;
                    unique_count_reg <= res_count;
                    count_reg        <= count_next;
                    state_reg        <= S_IDLE;
                    if (cmd_reg == CMD_NEW_PASS)
                    begin
                        epoch_reg <= epoch_next;
                        // epoch wrap: old tags could alias, wipe the table
                        if (epoch_next == '0)
                        begin
                            clr_addr_reg <= '0;
                            state_reg    <= S_CLEAR;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: sv/fsir_checker.sv
module fsir_checker
    import fsir_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input logic [RESULT_W-1:0] new_index,
    input logic                remapped,
    input logic                first_seen,
    input logic [COUNT_W-1:0]  unique_count
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result request dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(new_index) && $stable(unique_count)
            && $stable(remapped) && $stable(first_seen))
        else $error("stalled result changed");

    a_fresh_remap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && first_seen |-> remapped)
        else $error("first_seen without remapped");

    a_fresh_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && first_seen |-> unique_count != '0)
        else $error("fresh number left count at zero");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second request taken before the first finished");

endmodule

bind first_seen_index_renumbering fsir_checker u_fsir_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .new_index    (new_index),
    .remapped     (remapped),
    .first_seen   (first_seen),
    .unique_count (unique_count)
);
